>>> hdl/spfc_pkg.sv
package spfc_pkg;

	// schedule event layout inside a configuration word
	localparam int EVENT_BITS      = 21;
	localparam int EVENTS_PER_WORD = 3;
	localparam int WORD_W          = 63;
	localparam int COUNT_W         = 4;
	localparam int CFG_IDX_W       = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 3'd4;

	// output lanes on the result beat
	localparam int OUT_LANES = 3;
	localparam int DUTY_W    = 8;

	// beat widths
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	// one schedule event, hour in the lowest bits
	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] level;
		logic [5:0] minute;
		logic [4:0] hour;
	} event_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
	} sts_t;

endpackage

>>> hdl/spfc_ctrl.sv
module spfc_ctrl import spfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       slot_free;

	// output register can take a new result
	assign slot_free = !out_valid_q || m_tready;

	// commands
	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.start  = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.step   = (state_q == ST_SCAN) && !sts.scan_done;
	assign cmd.commit = (state_q == ST_COMMIT) && slot_free;
	assign m_tvalid   = out_valid_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_done) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hdl/spfc_dp.sv
module spfc_dp import spfc_pkg::*; #(
	parameter int MAX_EVENTS = 12,
	parameter int CHANNELS   = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_data,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int WORDS  = (MAX_EVENTS + EVENTS_PER_WORD - 1) / EVENTS_PER_WORD;
	localparam int SLOTS  = WORDS * EVENTS_PER_WORD;

	logic [WORD_W-1:0]  word_q [WORDS];
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_clamped;

	logic [4:0]         hour_q;
	logic [5:0]         minute_q;
	logic [COUNT_W-1:0] idx_q;
	logic [CHANNELS-1:0] found_q;
	logic [DUTY_W-1:0]  target_q [CHANNELS];

	logic [DUTY_W-1:0]  duty_q [CHANNELS];
	logic [CHANNELS-1:0] en_q;
	logic [DUTY_W-1:0]  duty_nxt [CHANNELS];
	logic [CHANNELS-1:0] en_nxt;

	logic [DUTY_W-1:0]  out_duty_q [OUT_LANES];
	logic [OUT_LANES-1:0] out_en_q;

	event_t             ev_all [SLOTS];
	event_t             ev_sel;
	logic               passed;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WORDS; w++) word_q[w] <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			for (int w = 0; w < WORDS; w++) begin
				if (cfg_index == CFG_IDX_W'(w)) word_q[w] <= cfg_data;
			end
			if (cfg_index == REG_EVENT_COUNT) count_q <= cfg_data[COUNT_W-1:0];
		end
	end

	assign count_clamped = (count_q > COUNT_W'(MAX_EVENTS)) ? COUNT_W'(MAX_EVENTS) : count_q;

	// unpack the schedule events
	for (genvar k = 0; k < SLOTS; k++) begin : g_ev
		assign ev_all[k] = event_t'(word_q[k / EVENTS_PER_WORD]
			[(k % EVENTS_PER_WORD) * EVENT_BITS +: EVENT_BITS]);
	end

	// event under the scan pointer, pointer counts down from count to one
	always_comb begin
		ev_sel = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (idx_q == COUNT_W'(k + 1)) ev_sel = ev_all[k];
		end
	end

	assign passed = (hour_q > ev_sel.hour) ||
		((hour_q == ev_sel.hour) && (minute_q >= ev_sel.minute));

	assign sts.scan_done = (idx_q == '0);

	// scan: the first passed event met per channel wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= '0;
		end else if (cmd.start) begin
			idx_q   <= count_clamped;
			found_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q - 1'b1;
			for (int c = 0; c < CHANNELS; c++) begin
				if (passed && ev_sel.channel == 2'(c) && !found_q[c]) found_q[c] <= 1'b1;
			end
		end
	end

	// time of day and targets
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hour_q   <= s_tdata[4:0];
			minute_q <= s_tdata[10:5];
		end
		if (cmd.step) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (passed && ev_sel.channel == 2'(c) && !found_q[c]) target_q[c] <= ev_sel.level;
			end
		end
	end

	// one fade step per governed channel
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			duty_nxt[c] = duty_q[c];
			en_nxt[c]   = en_q[c];
			if (found_q[c]) begin
				if (duty_q[c] < target_q[c]) begin
					duty_nxt[c] = duty_q[c] + 1'b1;
					en_nxt[c]   = 1'b1;
				end else if (duty_q[c] > target_q[c]) begin
					duty_nxt[c] = duty_q[c] - 1'b1;
					en_nxt[c]   = (duty_q[c] != DUTY_W'(1));
				end
			end
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) duty_q[c] <= '0;
			en_q <= '0;
		end else if (cmd.commit) begin
			for (int c = 0; c < CHANNELS; c++) duty_q[c] <= duty_nxt[c];
			en_q <= en_nxt;
		end
	end

	// result register, unused lanes read zero
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int c = 0; c < OUT_LANES; c++) begin
				if (c < CHANNELS) begin
					out_duty_q[c] <= duty_nxt[c];
					out_en_q[c]   <= en_nxt[c];
				end else begin
					out_duty_q[c] <= '0;
					out_en_q[c]   <= 1'b0;
				end
			end
		end
	end

	assign m_tdata = {5'b0, out_en_q, out_duty_q[2], out_duty_q[1], out_duty_q[0]};

endmodule

>>> hdl/scheduled_pwm_fade_controller.sv
// the event scan visits one schedule event per cycle, from the last counted event
// down to the first (count clamped to MAX_EVENTS), before the result is committed
// a new tick is taken only once the previous one has been committed
// a finished result waits in an output register while the next tick is taken
// reset: arst_n low clears schedule words, event count, duties and drive enables
module scheduled_pwm_fade_controller import spfc_pkg::*; #(
	parameter int MAX_EVENTS = 12,
	parameter int CHANNELS   = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // hour_now[4:0], minute_now[10:5], zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // duty_main[7:0], duty_front[15:8],
	                                         // duty_night[23:16], drive_enables[26:24], pad
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	spfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// schedule scan and fade datapath
	spfc_dp #(
		.MAX_EVENTS (MAX_EVENTS),
		.CHANNELS   (CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTHESIS
	// a committed result shows up as a valid beat
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("commit did not raise result valid");

	// no second tick is taken right after one is accepted
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("tick accepted while busy");

	// the main channel is never driven at zero duty
	a_drive_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[24] && m_tdata[7:0] == 8'd0))
		else $error("channel driven with zero duty");

	// commit only after the scan has finished
	a_commit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.scan_done)
		else $error("commit before scan done");
`endif

endmodule

>>> sim/fade_checker.sv
`timescale 1ns / 1ps

module fade_checker import spfc_pkg::*; #(
	parameter int MAX_EV = 12,
	parameter int NUM_CH = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // hour_now[4:0], minute_now[10:5], zero pad
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // duty_main[7:0], duty_front[15:8],
	                                         // duty_night[23:16], drive_enables[26:24], pad
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_data,
	output int                    mismatch_count,
	output int                    pending_count
);

	localparam int PAD_W = OUT_DATA_W - DUTY_W * OUT_LANES - OUT_LANES;

	// result beat layout, duty_main in the lowest bits
	typedef struct packed {
		logic [PAD_W-1:0]     pad;
		logic [OUT_LANES-1:0] drive;
		logic [DUTY_W-1:0]    duty_night;
		logic [DUTY_W-1:0]    duty_front;
		logic [DUTY_W-1:0]    duty_main;
	} fade_beat_t;

	// shadow of the schedule registers and the lamp state
	logic [WORD_W-1:0]    sched_word [4];
	logic [COUNT_W-1:0]   sched_count;
	logic [DUTY_W-1:0]    lamp_duty [OUT_LANES];
	logic [OUT_LANES-1:0] lamp_drive;
	fade_beat_t           fade_expect_q [$];

	// one tick: find the governing event per channel, then step each duty
	function automatic fade_beat_t advance_fades(input logic [4:0] hr, input logic [5:0] mn);
		int                   n;
		int                   e;
		int                   c;
		logic [WORD_W-1:0]    shifted;
		event_t               ev;
		logic [OUT_LANES-1:0] seen;
		logic [DUTY_W-1:0]    goal [OUT_LANES];
		fade_beat_t           r;
		n = (sched_count > MAX_EV) ? MAX_EV : sched_count;
		seen = '0;
		for (c = 0; c < OUT_LANES; c++)
			goal[c] = '0;
		// latest passed event wins, so walk from the last valid one down
		for (e = n - 1; e >= 0; e--) begin
			shifted = sched_word[e / EVENTS_PER_WORD] >> (EVENT_BITS * (e % EVENTS_PER_WORD));
			ev = shifted[EVENT_BITS-1:0];
			if ((hr > ev.hour || (hr == ev.hour && mn >= ev.minute)) &&
			    ev.channel < NUM_CH && !seen[ev.channel]) begin
				seen[ev.channel] = 1'b1;
				goal[ev.channel] = ev.level;
			end
		end
		for (c = 0; c < NUM_CH && c < OUT_LANES; c++) begin
			if (seen[c]) begin
				if (lamp_duty[c] < goal[c]) begin
					lamp_duty[c] = lamp_duty[c] + 1'b1;
					lamp_drive[c] = 1'b1;
				end else if (lamp_duty[c] > goal[c]) begin
					lamp_duty[c] = lamp_duty[c] - 1'b1;
					lamp_drive[c] = lamp_duty[c] != '0;
				end
			end
		end
		r = '0;
		r.duty_main = lamp_duty[0];
		r.duty_front = (NUM_CH > 1) ? lamp_duty[1] : '0;
		r.duty_night = (NUM_CH > 2) ? lamp_duty[2] : '0;
		for (c = 0; c < NUM_CH && c < OUT_LANES; c++)
			r.drive[c] = lamp_drive[c];
		return r;
	endfunction

	task automatic note_field(input string fld, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0d, got %0d", $time, fld, want, got);
		end
	endtask

	// watch config writes, input beats and result beats
	always @(posedge clk or negedge arst_n) begin
		fade_beat_t want;
		fade_beat_t got;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				sched_word[i] = '0;
			for (int i = 0; i < OUT_LANES; i++)
				lamp_duty[i] = '0;
			sched_count = '0;
			lamp_drive = '0;
			fade_expect_q.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < REG_EVENT_COUNT)
					sched_word[cfg_index[1:0]] = cfg_data;
				else if (cfg_index == REG_EVENT_COUNT)
					sched_count = cfg_data[COUNT_W-1:0];
			end
			if (s_tvalid && s_tready)
				fade_expect_q.push_back(advance_fades(s_tdata[4:0], s_tdata[10:5]));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (fade_expect_q.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: result beat expected none, got %h", $time, m_tdata);
				end else begin
					want = fade_expect_q.pop_front();
					note_field("duty_main", want.duty_main, got.duty_main);
					note_field("duty_front", want.duty_front, got.duty_front);
					note_field("duty_night", want.duty_night, got.duty_night);
					note_field("drive_enables", want.drive, got.drive);
					note_field("pad", want.pad, got.pad);
				end
			end
			pending_count = fade_expect_q.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import spfc_pkg::*;

	localparam int MAX_EVENTS  = 12;
	localparam int CHANNELS    = 3;
	localparam int TICK_TOTAL  = 1950;
	localparam int CALM_TAIL   = 300;
	localparam int LONG_HOLD   = 400;
	localparam int DAY_MINUTES = 1440;

	localparam logic [CFG_IDX_W-1:0] REG_EVENT_WORD_0 = '0;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_EVENT_COUNT + 1'b1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [WORD_W-1:0]     cfg_data = '0;

	int  mismatch_count;
	int  pending_count;
	int  sent = 0;
	bit  sender_idle = 1'b0;
	bit  receiver_idle = 1'b0;
	bit  long_hold_req = 1'b0;

	logic [WORD_W-1:0] plan_word [4];

	always #6 clk = ~clk;

	scheduled_pwm_fade_controller #(
		.MAX_EVENTS(MAX_EVENTS),
		.CHANNELS  (CHANNELS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	fade_checker #(
		.MAX_EV(MAX_EVENTS),
		.NUM_CH(CHANNELS)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatch_count(mismatch_count),
		.pending_count (pending_count)
	);

	function automatic event_t ev_of(input int hr, input int mn, input int lvl, input int ch);
		event_t ev;
		ev.hour = hr[4:0];
		ev.minute = mn[5:0];
		ev.level = lvl[7:0];
		ev.channel = ch[1:0];
		return ev;
	endfunction

	task automatic place_event(input int idx, input event_t ev);
		plan_word[idx / EVENTS_PER_WORD][EVENT_BITS * (idx % EVENTS_PER_WORD) +: EVENT_BITS] = ev;
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[WORD_W-1:0];
	endfunction

	// schedule words, an ignored index when noisy, then the event count
	task automatic load_schedule(input int cnt, input bit noisy);
		int                w;
		logic [WORD_W-1:0] count_word;
		for (w = 0; w < 4; w++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_EVENT_WORD_0 + CFG_IDX_W'(w);
			cfg_data <= plan_word[w];
			@(posedge clk);
		end
		if (noisy) begin
			cfg_index <= REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2));
			cfg_data <= rand_word();
			@(posedge clk);
		end
		count_word = noisy ? rand_word() : '0;
		count_word[COUNT_W-1:0] = COUNT_W'(cnt);
		cfg_index <= REG_EVENT_COUNT;
		cfg_data <= count_word;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one tick beat, with an optional gap before it
	task automatic send_tick(input int hr, input int mn);
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - 11){1'b0}}, mn[5:0], hr[4:0]};
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_fades();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		@(posedge clk);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// run limit
	initial begin
		#(10_000_000);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int w;
		int e;
		int k;
		int cnt;
		int t;
		int t_first;
		int n_ticks;
		int phase;
		int lvl;
		int ch;
		bit small_levels;
		bit noisy;
		bit calm;

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// directed schedule: extreme times, ignored channel, count above the max
		for (w = 0; w < 4; w++)
			plan_word[w] = '0;
		place_event(0, ev_of(0, 0, 255, 0));
		place_event(1, ev_of(0, 0, 2, 1));
		place_event(2, ev_of(0, 0, 0, 2));
		place_event(3, ev_of(6, 15, 7, 2));
		place_event(4, ev_of(12, 30, 1, 0));
		place_event(5, ev_of(12, 30, 200, 3));
		place_event(6, ev_of(23, 59, 0, 1));
		place_event(7, ev_of(24, 0, 9, 2));
		place_event(8, ev_of(31, 63, 255, 2));
		place_event(9, ev_of(16, 0, 0, 3));
		place_event(10, ev_of(31, 0, 128, 1));
		place_event(11, ev_of(31, 63, 0, 0));
		load_schedule(15, 1'b0);
		send_tick(0, 0);
		send_tick(0, 0);
		send_tick(0, 0);
		send_tick(6, 14);
		send_tick(6, 15);
		send_tick(6, 15);
		send_tick(12, 29);
		send_tick(12, 30);
		send_tick(12, 30);
		send_tick(23, 59);
		send_tick(23, 59);
		send_tick(24, 0);
		send_tick(31, 63);
		send_tick(31, 63);
		send_tick(31, 0);
		drain_fades();

		// empty schedule: duties hold whatever the time
		load_schedule(0, 1'b1);
		send_tick(12, 0);
		send_tick(23, 59);
		send_tick(0, 0);
		send_tick(31, 63);

		// random phases, each with its own schedule and a walk through the day
		phase = 0;
		while (sent < TICK_TOTAL) begin
			drain_fades();
			calm = sent >= TICK_TOTAL - CALM_TAIL;
			sender_idle = !calm && $urandom_range(0, 4) != 0;
			receiver_idle = !calm && $urandom_range(0, 4) != 0;
			noisy = 1'b0;
			if (phase == 1) begin
				for (w = 0; w < 4; w++)
					plan_word[w] = '1;
				cnt = MAX_EVENTS;
				t_first = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				noisy = 1'b1;
				for (w = 0; w < 4; w++)
					plan_word[w] = rand_word();
				cnt = $urandom_range(0, 15);
				t_first = $urandom_range(0, DAY_MINUTES - 1);
			end else begin
				// chronological events; slots past the count hold junk
				small_levels = 1'($urandom_range(0, 1));
				for (w = 0; w < 4; w++)
					plan_word[w] = rand_word();
				cnt = $urandom_range(1, MAX_EVENTS);
				t = $urandom_range(0, 600);
				t_first = t;
				for (e = 0; e < cnt; e++) begin
					if (small_levels)
						lvl = $urandom_range(0, 6);
					else if ($urandom_range(0, 7) == 0)
						lvl = $urandom_range(0, 1) * 255;
					else
						lvl = $urandom_range(0, 255);
					ch = ($urandom_range(0, 11) == 0) ? 3 : $urandom_range(0, CHANNELS - 1);
					place_event(e, ev_of(t / 60, t % 60, lvl, ch));
					t = t + $urandom_range(0, 120);
					if (t > DAY_MINUTES - 1)
						t = DAY_MINUTES - 1;
				end
			end
			load_schedule(cnt, noisy);
			if (phase == 3)
				long_hold_req = 1'b1;
			t = (t_first + DAY_MINUTES - $urandom_range(0, 30)) % DAY_MINUTES;
			n_ticks = $urandom_range(30, 90);
			for (k = 0; k < n_ticks; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_tick($urandom_range(0, 31), $urandom_range(0, 63));
				end else begin
					send_tick(t / 60, t % 60);
					if ($urandom_range(0, 3) == 0)
						t = (t + $urandom_range(1, 40)) % DAY_MINUTES;
				end
			end
			phase++;
		end

		drain_fades();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
